@@ hw/rtl/stream_pattern_search_defines.svh @@
// ---------------------------------------------------------------------------
// stream_pattern_search assertion macros
// Clocked, reset-qualified property shorthands for the search block.
// ---------------------------------------------------------------------------
`ifndef STREAM_PATTERN_SEARCH_DEFINES_SVH
`define STREAM_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication on aclk, idle during reset.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, idle during reset.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sps_pkg.sv @@
// ---------------------------------------------------------------------------
// sps_pkg
// Shared constants and types of the stream pattern search block.
// ---------------------------------------------------------------------------
package sps_pkg;

    // Fixed field widths of the ports
    localparam int ELEM_PORT_W   = 16;
    localparam int INDEX_W       = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int LEN_REG_W     = 5;
    // Pattern elements held in the configuration words
    localparam int REG_ELEMS     = 16;
    localparam int WORD_ELEMS    = 4;
    localparam int NUM_WORDS     = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3 = 3'd4;

    localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RESET = 5'd1;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic               overflow;
    } result_t;

endpackage

@@ hw/rtl/stream_pattern_search.sv @@
// ---------------------------------------------------------------------------
// stream_pattern_search
// Streaming substring search over a haystack delivered one item per cycle.
// ---------------------------------------------------------------------------
// Each accepted item is one haystack element. The block compares the newest
// pattern_len elements against the configured pattern in parallel and keeps
// the start index of the earliest full match. The item flagged last_element
// produces one result (found, match_index, overflow) and clears the stream
// state. Throughput is one item per cycle: an item waits in the input
// register, is folded into the window, counter and match state when it
// advances, and a last item's result lands in the output register at that
// edge, which raises m_valid. s_ready drops only while a last item waits
// behind a result that m_ready has not taken. Configuration writes apply
// to items accepted after the write; the pattern is re-aligned to the
// length in a register stage.
// ---------------------------------------------------------------------------
`include "stream_pattern_search_defines.svh"

module stream_pattern_search #(
    parameter int PAT_MAX   = 16,
    parameter int ELEM_BITS = 16,
    parameter longint unsigned MAX_LEN = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // haystack items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sps_pkg::ELEM_PORT_W-1:0]  s_element,
    input  logic                             s_last_element,
    // search results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [sps_pkg::INDEX_W-1:0]      m_match_index,
    output logic                             m_overflow
);
    import sps_pkg::*;

    localparam int LEN_W = $clog2(PAT_MAX + 1);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // Input register
    logic                   in_valid_reg, in_valid_next;
    logic [ELEM_PORT_W-1:0] in_elem_reg;
    logic                   in_last_reg;
    logic                   s_accept;
    logic                   advance;

    // Pattern view from the configuration block
    logic [ELEM_BITS-1:0]   aligned_pat [PAT_MAX];
    logic [PAT_MAX-1:0]     care_mask;
    logic [LEN_W-1:0]       eff_len;

    // Result register
    logic                   res_valid;
    result_t                res;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg;

    sps_cfg_regs #(
        .PAT_MAX   (PAT_MAX),
        .ELEM_BITS (ELEM_BITS),
        .LEN_W     (LEN_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .aligned_pat (aligned_pat),
        .care_mask   (care_mask),
        .eff_len     (eff_len)
    );

    // A non-last item always moves on; a last item needs room for its result
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_elem_reg <= s_element;
            in_last_reg <= s_last_element;
        end
    end

    sps_match_core #(
        .PAT_MAX   (PAT_MAX),
        .ELEM_BITS (ELEM_BITS),
        .LEN_W     (LEN_W),
        .CNT_W     (CNT_W),
        .MAX_LEN   (MAX_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .elem        (in_elem_reg),
        .last        (in_last_reg),
        .aligned_pat (aligned_pat),
        .care_mask   (care_mask),
        .eff_len     (eff_len),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = out_reg.found;
    assign m_match_index = out_reg.match_index;
    assign m_overflow    = out_reg.overflow;

    // Checks
    `SPS_ASSERT_NOW(a_index_zero_when_not_found, m_valid && !m_found, m_match_index == '0, "match_index set without a match")
    `SPS_ASSERT_NOW(a_last_waits_for_room, in_valid_reg && in_last_reg && m_valid && !m_ready, !s_ready && !advance, "last item advanced over a pending result")
    `SPS_ASSERT_NEXT(a_last_gives_result, advance && in_last_reg, m_valid, "last item did not produce a result")

endmodule

@@ hw/rtl/sps_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// sps_cfg_regs
// Configuration registers and the length-aligned, registered pattern view.
// ---------------------------------------------------------------------------
module sps_cfg_regs #(
    parameter int PAT_MAX   = 16,
    parameter int ELEM_BITS = 16,
    parameter int LEN_W     = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // aligned_pat[j] is the pattern element that window entry j must equal
    output logic [ELEM_BITS-1:0]           aligned_pat [PAT_MAX],
    output logic [PAT_MAX-1:0]             care_mask,
    output logic [LEN_W-1:0]               eff_len
);
    import sps_pkg::*;

    logic [LEN_REG_W-1:0]  pattern_len_reg;
    logic [CFG_DATA_W-1:0] word_reg [NUM_WORDS];

    logic [ELEM_BITS-1:0]  pat_elem [PAT_MAX];
    logic [ELEM_BITS-1:0]  aligned_next [PAT_MAX];
    logic [ELEM_BITS-1:0]  aligned_reg [PAT_MAX];
    logic [PAT_MAX-1:0]    care_next;
    logic [PAT_MAX-1:0]    care_reg;
    logic [LEN_W-1:0]      len_next;
    logic [LEN_W-1:0]      len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg <= PATTERN_LEN_RESET;
            for (int w = 0; w < NUM_WORDS; w++) begin
                word_reg[w] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LEN:   pattern_len_reg <= cfg_wdata[LEN_REG_W-1:0];
                REG_PATTERN_WORD0: word_reg[0] <= cfg_wdata;
                REG_PATTERN_WORD1: word_reg[1] <= cfg_wdata;
                REG_PATTERN_WORD2: word_reg[2] <= cfg_wdata;
                REG_PATTERN_WORD3: word_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp length into 1..PAT_MAX
    always_comb begin
        if (pattern_len_reg == '0) begin
            len_next = LEN_W'(1);
        end else if (int'(pattern_len_reg) > PAT_MAX) begin
            len_next = LEN_W'(PAT_MAX);
        end else begin
            len_next = LEN_W'(pattern_len_reg);
        end
    end

    // Unpack elements; those past the register words read as zero
    always_comb begin
        logic [31:0] wide;
        for (int k = 0; k < PAT_MAX; k++) begin
            wide = '0;
            if (k < REG_ELEMS) begin
                wide = 32'(word_reg[2'(k >> 2)][(k & 3) * ELEM_PORT_W +: ELEM_PORT_W]);
            end
            pat_elem[k] = wide[ELEM_BITS-1:0];
        end
    end

    // Window entry j holds the element aligned with pattern element len-1-j
    always_comb begin
        for (int j = 0; j < PAT_MAX; j++) begin
            aligned_next[j] = '0;
            care_next[j]    = (j < int'(len_next));
            for (int k = 0; k < PAT_MAX; k++) begin
                if (j < int'(len_next) && k == int'(len_next) - 1 - j) begin
                    aligned_next[j] = pat_elem[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            care_reg <= PAT_MAX'(1);
            len_reg  <= LEN_W'(1);
        end else begin
            care_reg <= care_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < PAT_MAX; j++) begin
            aligned_reg[j] <= aligned_next[j];
        end
    end

    assign aligned_pat = aligned_reg;
    assign care_mask   = care_reg;
    assign eff_len     = len_reg;

endmodule

@@ hw/rtl/sps_match_core.sv @@
// ---------------------------------------------------------------------------
// sps_match_core
// Element window, position counter and parallel compare for one stream.
// ---------------------------------------------------------------------------
module sps_match_core #(
    parameter int PAT_MAX   = 16,
    parameter int ELEM_BITS = 16,
    parameter int LEN_W     = 5,
    parameter int CNT_W     = 17,
    parameter longint unsigned MAX_LEN = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic [sps_pkg::ELEM_PORT_W-1:0]  elem,
    input  logic                             last,
    input  logic [ELEM_BITS-1:0]             aligned_pat [PAT_MAX],
    input  logic [PAT_MAX-1:0]               care_mask,
    input  logic [LEN_W-1:0]                 eff_len,
    output logic                             res_valid,
    output sps_pkg::result_t                 res
);
    import sps_pkg::*;

    localparam int SUM_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

    logic [ELEM_BITS-1:0] window_reg [PAT_MAX];
    logic [ELEM_BITS-1:0] window_shift [PAT_MAX];
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic                 match_seen_reg, match_seen_next;
    logic [INDEX_W-1:0]   start_reg, start_next;
    logic                 sat_reg, sat_next;

    logic [31:0]          elem_wide;
    logic                 hit;
    logic [SUM_W-1:0]     seen_plus;
    logic [SUM_W-1:0]     start_full;

    assign elem_wide = 32'(elem);

    always_comb begin
        window_shift[0] = elem_wide[ELEM_BITS-1:0];
        for (int j = 1; j < PAT_MAX; j++) begin
            window_shift[j] = window_reg[j-1];
        end
    end

    always_comb begin
        hit = 1'b1;
        for (int j = 0; j < PAT_MAX; j++) begin
            if (care_mask[j] && window_shift[j] != aligned_pat[j]) begin
                hit = 1'b0;
            end
        end
    end

    assign seen_plus  = SUM_W'(seen_reg) + SUM_W'(1);
    assign start_full = seen_plus - SUM_W'(eff_len);

    always_comb begin
        seen_next       = seen_reg;
        match_seen_next = match_seen_reg;
        start_next      = start_reg;
        sat_next        = sat_reg;
        if (seen_reg == CNT_W'(MAX_LEN)) begin
            sat_next = 1'b1;
        end else begin
            seen_next = seen_plus[CNT_W-1:0];
            // only positions fully inside this stream can match
            if (!match_seen_reg && seen_plus >= SUM_W'(eff_len) && hit) begin
                match_seen_next = 1'b1;
                start_next      = start_full[INDEX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= '0;
            match_seen_reg <= 1'b0;
            start_reg      <= '0;
            sat_reg        <= 1'b0;
        end else if (advance) begin
            if (last) begin
                seen_reg       <= '0;
                match_seen_reg <= 1'b0;
                start_reg      <= '0;
                sat_reg        <= 1'b0;
            end else begin
                seen_reg       <= seen_next;
                match_seen_reg <= match_seen_next;
                start_reg      <= start_next;
                sat_reg        <= sat_next;
            end
        end
    end

    // Window needs no clear: the count check keeps stale entries out
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int j = 0; j < PAT_MAX; j++) begin
                window_reg[j] <= window_shift[j];
            end
        end
    end

    assign res_valid       = advance && last;
    assign res.found       = match_seen_next;
    assign res.match_index = match_seen_next ? start_next : '0;
    assign res.overflow    = sat_next;

endmodule

@@ verif/sps_result_checker.sv @@
// ---------------------------------------------------------------------------
// sps_result_checker
// Watches the configuration port and both streams of the search block,
// predicts every search result and compares it with what the block returns.
// ---------------------------------------------------------------------------
module sps_result_checker
    import sps_pkg::*;
#(
    parameter int unsigned MAX_LEN = 65536
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [ELEM_PORT_W-1:0] s_element,
    input  logic                   s_last_element,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_found,
    input  logic [INDEX_W-1:0]     m_match_index,
    input  logic                   m_overflow,
    output int                     fail_count,
    output int                     results_pending
);

    localparam int WINDOW_DEPTH = REG_ELEMS;
    localparam int REPORT_LIMIT = 10;

    // mirrored configuration
    logic [LEN_REG_W-1:0]   len_code;
    logic [CFG_DATA_W-1:0]  pattern_words [NUM_WORDS];

    // per-stream search state; window[0] is the newest item
    logic [ELEM_PORT_W-1:0] window [WINDOW_DEPTH];
    logic [16:0]            elements_counted;
    logic                   matched;
    logic [INDEX_W-1:0]     match_start;
    logic                   saturated;

    result_t                search_outcomes [$];

    function automatic logic [ELEM_PORT_W-1:0] pattern_at(input int unsigned k);
        return pattern_words[k / WORD_ELEMS][(k % WORD_ELEMS) * ELEM_PORT_W +: ELEM_PORT_W];
    endfunction

    function automatic int unsigned active_len();
        if (len_code == '0)
            return 1;
        if (len_code > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return len_code;
    endfunction

    task automatic clear_stream();
        foreach (window[k]) window[k] = '0;
        elements_counted = '0;
        matched          = 1'b0;
        match_start      = '0;
        saturated        = 1'b0;
    endtask

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%t checker: %s", $realtime, msg);
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_PATTERN_LEN:   len_code = data[LEN_REG_W-1:0];
            REG_PATTERN_WORD0,
            REG_PATTERN_WORD1,
            REG_PATTERN_WORD2,
            REG_PATTERN_WORD3: pattern_words[index - REG_PATTERN_WORD0] = data;
            default: ;  // spare indexes are ignored
        endcase
    endtask

    // Fold one haystack item into the search; a last item closes the stream.
    task automatic advance_search(input logic [ELEM_PORT_W-1:0] value,
                                  input logic is_last);
        int unsigned plen;
        int unsigned pos;
        int unsigned k;
        bit          hit;
        result_t     outcome;
        plen = active_len();
        for (k = WINDOW_DEPTH - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = value;
        if (elements_counted >= MAX_LEN) begin
            saturated = 1'b1;
        end else begin
            pos = elements_counted;
            elements_counted = elements_counted + 1'b1;
            // too few items of this stream: zeros left by the clear never match
            if (!matched && elements_counted >= plen) begin
                hit = 1'b1;
                for (k = 0; k < plen; k++)
                    if (window[plen - 1 - k] != pattern_at(k))
                        hit = 1'b0;
                if (hit) begin
                    matched     = 1'b1;
                    match_start = INDEX_W'(pos + 1 - plen);
                end
            end
        end
        if (is_last) begin
            outcome.found       = matched;
            outcome.match_index = matched ? match_start : '0;
            outcome.overflow    = saturated;
            search_outcomes.push_back(outcome);
            clear_stream();
        end
    endtask

    task automatic check_result();
        result_t want;
        if (search_outcomes.size() == 0) begin
            report_failure($sformatf("unexpected result found=%0d index=%0d overflow=%0d",
                                     m_found, m_match_index, m_overflow));
        end else begin
            want = search_outcomes.pop_front();
            if (want.found !== m_found || want.match_index !== m_match_index
                    || want.overflow !== m_overflow)
                report_failure($sformatf(
                    "expected found=%0d index=%0d overflow=%0d, got found=%0d index=%0d overflow=%0d",
                    want.found, want.match_index, want.overflow,
                    m_found, m_match_index, m_overflow));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            len_code = PATTERN_LEN_RESET;
            foreach (pattern_words[w]) pattern_words[w] = '0;
            clear_stream();
            search_outcomes.delete();
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                advance_search(s_element, s_last_element);
            if (cfg_wr_en)
                apply_write(cfg_index, cfg_wdata);
        end
        results_pending = search_outcomes.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stream pattern search block.
// ---------------------------------------------------------------------------
// Haystacks are sent as streams under a sequence of pattern settings:
// a directed opening on the reset pattern, zero and oversize length codes,
// stale-window and full-length matches; streams at and past the 65536-item
// counter limit; then random streams seeded with whole, partial and cut-off
// copies of the pattern. sps_result_checker predicts and compares every
// result; this module only drives the ports and reports the outcome.
// ---------------------------------------------------------------------------
module tb_top;
    import sps_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;       // result lands once its last item leaves the input register
    localparam int END_CYCLES     = 8;
    localparam int LONG_HOLD      = 48;      // receiver hold-off that backs up the block
    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int PHASE_ITEMS    = 75;
    localparam int unsigned HAYSTACK_LIMIT = 65536;

    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = REG_PATTERN_WORD3 + 1'b1;

    // how a copy of the pattern is planted into a random haystack
    typedef enum int unsigned {
        PLANT_NONE,
        PLANT_FULL,     // whole pattern somewhere inside
        PLANT_TAIL,     // leading part of the pattern cut off by the last item
        PLANT_EXACT     // haystack is exactly the pattern
    } plant_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [ELEM_PORT_W-1:0] s_element      = '0;
    logic                   s_last_element = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic                   m_found;
    logic [INDEX_W-1:0]     m_match_index;
    logic                   m_overflow;

    int fail_count;
    int results_pending;

    // idling controls of the sender and the receiver
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;
    logic        hold_req   = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    // pattern currently programmed, as the stimulus sees it
    logic [ELEM_PORT_W-1:0] pat_elem [REG_ELEMS];
    int unsigned            pat_eff = 1;

    stream_pattern_search dut (.*);

    sps_result_checker #(.MAX_LEN(HAYSTACK_LIMIT)) u_checker (.*);

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold on request.
    // Exactly one assignment to m_ready per falling edge.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            hold_req  <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    // Values biased toward the extremes and a few repeats, so patterns
    // have self-overlap and the haystack has near misses.
    function automatic logic [ELEM_PORT_W-1:0] pick_pattern_value();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return 16'h00A5;
            3:       return 16'h8001;
            default: return ELEM_PORT_W'($urandom);
        endcase
    endfunction

    function automatic logic [ELEM_PORT_W-1:0] pick_element();
        case ($urandom_range(0, 3))
            0, 1:    return pat_elem[$urandom_range(0, pat_eff - 1)];
            2:       return pick_pattern_value();
            default: return ELEM_PORT_W'($urandom);
        endcase
    endfunction

    // One item on the input channel; may idle first, then holds until taken.
    task automatic push_item(input logic [ELEM_PORT_W-1:0] value, input logic is_last);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_element      <= value;
        s_last_element <= is_last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every result is back and the pipe is quiet.
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    // Writes length and all four pattern words from pat_elem; sometimes
    // also a spare index, which must leave the pattern alone.
    task automatic program_pattern(input logic [LEN_REG_W-1:0] len_code);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_IDX_W-1:0]  index;
        int unsigned           w;
        int unsigned           k;
        word = {$urandom, $urandom};    // junk above the length field
        word[LEN_REG_W-1:0] = len_code;
        write_reg(REG_PATTERN_LEN, word);
        for (w = 0; w < NUM_WORDS; w++) begin
            for (k = 0; k < WORD_ELEMS; k++)
                word[k * ELEM_PORT_W +: ELEM_PORT_W] = pat_elem[w * WORD_ELEMS + k];
            index = REG_PATTERN_WORD0 + w[CFG_IDX_W-1:0];
            write_reg(index, word);
        end
        if ($urandom_range(0, 1) == 1) begin
            index = SPARE_INDEX_LO + CFG_IDX_W'($urandom_range(0, 2));
            write_reg(index, {$urandom, $urandom});
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        pat_eff = (len_code == 0) ? 1 : (len_code > REG_ELEMS) ? REG_ELEMS : len_code;
    endtask

    task automatic send_stream(input int unsigned hay_len, output int unsigned pushed);
        logic [ELEM_PORT_W-1:0] hay [$];
        plant_t                 how;
        int unsigned            at;
        int unsigned            cut;
        int unsigned            k;
        hay = {};
        for (k = 0; k < hay_len; k++)
            hay.push_back(pick_element());
        how = plant_t'($urandom_range(0, 3));
        case (how)
            PLANT_FULL: begin
                while (hay.size() < pat_eff)
                    hay.push_back(pick_element());
                at = $urandom_range(0, hay.size() - pat_eff);
                for (k = 0; k < pat_eff; k++)
                    hay[at + k] = pat_elem[k];
            end
            PLANT_TAIL: begin
                cut = $urandom_range(1, pat_eff);
                while (hay.size() < cut)
                    hay.push_back(pick_element());
                at = hay.size() - cut;
                for (k = 0; k < cut; k++)
                    hay[at + k] = pat_elem[k];
            end
            PLANT_EXACT: begin
                hay = {};
                for (k = 0; k < pat_eff; k++)
                    hay.push_back(pat_elem[k]);
            end
            default: ;
        endcase
        for (k = 0; k < hay.size(); k++)
            push_item(hay[k], k == hay.size() - 1);
        pushed = hay.size();
    endtask

    // Very long stream at full rate: filler never equals a pattern item,
    // a pattern copy at early_at (if inside) and one ending on the last item.
    task automatic send_long(input int unsigned total, input int unsigned early_at);
        logic [ELEM_PORT_W-1:0] value;
        int unsigned            tail_at;
        int unsigned            i;
        tail_at = total - pat_eff;
        for (i = 0; i < total; i++) begin
            if (i >= early_at && i < early_at + pat_eff)
                value = pat_elem[i - early_at];
            else if (i >= tail_at)
                value = pat_elem[i - tail_at];
            else
                value = {8'h10, i[7:0]};
            push_item(value, i == total - 1);
        end
    endtask

    // Long receiver hold while the sender keeps streaming short haystacks,
    // so results back up and the input stalls.
    task automatic squeeze_receiver(output int unsigned pushed);
        int unsigned k;
        int unsigned n;
        bit          keep_idle;
        keep_idle  = tx_idle_en;
        tx_idle_en = 1'b0;
        hold_req  <= 1'b1;
        pushed     = 0;
        for (k = 0; k < 12; k++) begin
            send_stream($urandom_range(1, 3), n);
            pushed += n;
        end
        tx_idle_en = keep_idle;
    endtask

    task automatic random_phase(input logic [LEN_REG_W-1:0] len_code, input bit with_hold);
        int unsigned sent;
        int unsigned n;
        int unsigned hay_len;
        int unsigned k;
        bit          squeezed;
        for (k = 0; k < REG_ELEMS; k++)
            pat_elem[k] = pick_pattern_value();
        program_pattern(len_code);
        sent     = 0;
        squeezed = 1'b0;
        while (sent < PHASE_ITEMS) begin
            if (with_hold && !squeezed && sent >= PHASE_ITEMS / 2) begin
                squeeze_receiver(n);
                sent    += n;
                squeezed = 1'b1;
            end
            // mostly short haystacks, now and then a longer one
            hay_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 16);
            send_stream(hay_len, n);
            sent += n;
        end
        drain_results();
    endtask

    initial begin
        int unsigned k;
        foreach (pat_elem[i]) pat_elem[i] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // reset pattern: one zero item
        push_item(16'h1234, 1'b0);
        push_item(16'h0000, 1'b1);
        drain_results();

        // length 4 on the all-zero pattern: a two-item stream must not hit
        // the cleared window, a four-item one matches at 0
        program_pattern(5'd4);
        push_item(16'h0000, 1'b0);
        push_item(16'h0000, 1'b1);
        for (k = 0; k < 4; k++)
            push_item(16'h0000, k == 3);
        drain_results();

        // length code zero acts as one
        pat_elem[0] = 16'hFFFF;
        program_pattern(5'd0);
        push_item(16'hFFFF, 1'b1);
        push_item(16'h0001, 1'b1);
        drain_results();

        // oversize length code acts as the full sixteen
        for (k = 0; k < REG_ELEMS; k++)
            pat_elem[k] = ELEM_PORT_W'((k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF
                                                 : 16'h1000 + 16'h0111 * k);
        program_pattern(5'd31);
        for (k = 0; k < REG_ELEMS; k++)
            push_item(pat_elem[k], k == REG_ELEMS - 1);
        drain_results();

        // counter limit: one stream of exactly the limit with a match ending
        // on its last item, one past it with an early match and a late copy
        // that lands after saturation
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        foreach (pat_elem[i]) pat_elem[i] = '0;
        pat_elem[0] = 16'hA1A1;
        pat_elem[1] = 16'hB2B2;
        pat_elem[2] = 16'hC3C3;
        program_pattern(5'd3);
        send_long(HAYSTACK_LIMIT, HAYSTACK_LIMIT);
        send_long(HAYSTACK_LIMIT + 3, 16'h5A5A);
        drain_results();

        // random phases across the length range
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        random_phase(5'd1, 1'b0);
        random_phase(5'd16, 1'b0);
        random_phase(5'd0, 1'b1);
        random_phase(LEN_REG_W'($urandom_range(17, 31)), 1'b0);
        random_phase(LEN_REG_W'($urandom_range(2, 15)), 1'b0);
        random_phase(5'd31, 1'b0);
        random_phase(LEN_REG_W'($urandom_range(2, 15)), 1'b0);

        // closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_phase(LEN_REG_W'($urandom_range(1, 16)), 1'b0);

        repeat (END_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
